// File: hw/rtl/bvps_pkg.sv
package bvps_pkg;

  localparam int COEF_W     = 17;
  localparam int POS_W      = 26;
  localparam int VEL_W      = 27;
  localparam int QUO_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 26;
  localparam int MUL_A_W    = 28;
  localparam int MUL_B_W    = 18;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int VSUM_W     = 30;

  localparam int DENSITY_START_DEF = 32768;

  localparam logic [COEF_W-1:0] ONE_Q16 = 17'd65536;

  localparam logic signed [VEL_W-1:0] VEL_MAX = 27'sh3FFFFFF;
  localparam logic signed [VEL_W-1:0] VEL_MIN = -27'sh4000000;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIFT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRAG     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEAT_UP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEAT_DN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DENS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TOP      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GROUND   = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ALT,
    ST_ALT_WAIT,
    ST_DENS,
    ST_DENS_WAIT,
    ST_MT,
    ST_MT_RD,
    ST_HL,
    ST_LIFT,
    ST_VEL,
    ST_DRAG,
    ST_POS
  } state_t;

  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [VSUM_W-1:0] v);
    logic signed [VEL_W-1:0] r;
    if (v > VSUM_W'(VEL_MAX)) begin
      r = VEL_MAX;
    end else if (v < VSUM_W'(VEL_MIN)) begin
      r = VEL_MIN;
    end else begin
      r = v[VEL_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/bvps_div.sv
module bvps_div
  import bvps_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [POS_W-1:0]    num,
  input  logic [POS_W-1:0]    den,
  output logic [QUO_W-1:0]    quo,
  output logic                done
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [POS_W-1:0] rem;
  logic [POS_W-1:0] den_r;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [POS_W:0]   rem_sh;
  logic             ge;

  // restoring division, one quotient bit a cycle; num must be below den
  assign rem_sh = {rem, 1'b0};
  assign ge     = rem_sh >= {1'b0, den_r};
  assign done   = busy && (cnt == CNT_W'(QUO_W));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      if (done) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num;
      den_r <= den;
      quo   <= '0;
    end else if (busy && !done) begin
      rem <= ge ? POS_W'(rem_sh - {1'b0, den_r}) : rem_sh[POS_W-1:0];
      quo <= {quo[QUO_W-2:0], ge};
    end
  end

endmodule

// File: hw/rtl/bvps_mul.sv
module bvps_mul
  import bvps_pkg::*;
(
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] op_a,
  input  logic        [MUL_B_W-1:0] op_b,
  output logic signed [PROD_W-1:0]  prod
);

  // op_b is always a non-negative coefficient
  always_ff @(posedge clk) begin
    prod <= op_a * $signed(op_b);
  end

endmodule

// File: hw/rtl/buoyant_vertical_physics_step.sv
// sequence: after an input transfer the altitude and density divisions run on the shared
// divider and are skipped when the altitude or density is clamped, then the products go
// through one multiplier before the result is stored in the output register
// input: a new input is taken once the result is stored, not while a tick is in progress
// reset: synchronous; heat, velocity and position go to zero, registers to their defaults
module buoyant_vertical_physics_step
  import bvps_pkg::*;
#(
  parameter int DENSITY_START_Q16 = DENSITY_START_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // burner
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [71:0]           m_axis_tdata,   // position, velocity, heat_level, at_top, at_ground
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [COEF_W-1:0] START = COEF_W'(DENSITY_START_Q16);
  localparam logic [COEF_W-1:0] SPAN  = COEF_W'(65536 - DENSITY_START_Q16);

  state_t state, state_next;

  logic [COEF_W-1:0] gravity_pull, lift_gain, drag_factor, heat_gain, heat_loss, min_density;
  logic [POS_W-1:0]  top_limit, ground_limit;

  logic [COEF_W-1:0]       heat_store;
  logic signed [VEL_W-1:0] velocity_store;
  logic [POS_W-1:0]        position_store;

  logic [COEF_W-1:0]       alt;
  logic [COEF_W-1:0]       dens;
  logic [QUO_W-1:0]        t_q;
  logic signed [VEL_W-1:0] vel_tmp;

  logic [POS_W-1:0]        out_position;
  logic signed [VEL_W-1:0] out_velocity;
  logic [COEF_W-1:0]       out_heat;
  logic                    out_top, out_ground;

  logic                      div_start, div_done;
  logic [POS_W-1:0]          div_num, div_den;
  logic [QUO_W-1:0]          div_quo;
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic signed [PROD_W-1:0]  prod;

  logic              in_xfer, out_free;
  logic [COEF_W:0]   heat_sum;
  logic [COEF_W-1:0] heat_upd;
  logic [COEF_W-1:0] dens_floor, onem_floor;
  logic              alt_trivial;
  logic [COEF_W-1:0] alt_triv;
  logic [POS_W-1:0]  alt_num, alt_den;
  logic [COEF_W-1:0] dens_off;
  logic [COEF_W-1:0] dens_calc;
  logic signed [VSUM_W-1:0] vel_sum;
  logic signed [VEL_W-1:0]  vel_drag;
  logic signed [POS_W+2:0]  pos_sum;
  logic                     hit_top, hit_ground;
  logic signed [POS_W+2:0]  pos_top;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);

  // heat update
  assign heat_sum = {1'b0, heat_store} + {1'b0, heat_gain};
  always_comb begin
    if (s_axis_tdata[0]) begin
      heat_upd = (heat_sum > {1'b0, ONE_Q16}) ? ONE_Q16 : heat_sum[COEF_W-1:0];
    end else begin
      heat_upd = (heat_store > heat_loss) ? heat_store - heat_loss : '0;
    end
  end

  // altitude set-up, clamped cases need no division
  assign alt_num = ground_limit - position_store;
  assign alt_den = ground_limit - top_limit;
  always_comb begin
    alt_trivial = 1'b1;
    alt_triv    = '0;
    if (ground_limit <= top_limit || position_store >= ground_limit) begin
      alt_triv = '0;
    end else if (alt_num >= alt_den) begin
      alt_triv = ONE_Q16;
    end else begin
      alt_trivial = 1'b0;
    end
  end

  assign dens_floor = (min_density > ONE_Q16) ? ONE_Q16 : min_density;
  assign onem_floor = ONE_Q16 - dens_floor;
  assign dens_off   = alt - START;
  always_comb begin
    dens_calc = ONE_Q16 - {1'b0, prod[QUO_W+15:16]};
    if (dens_calc < dens_floor) begin
      dens_calc = dens_floor;
    end
  end

  assign vel_sum  = VSUM_W'(velocity_store) + VSUM_W'(gravity_pull) - VSUM_W'(prod[32:16]);
  assign vel_drag = sat_vel(prod[PROD_W-1:16]);
  assign pos_sum  = $signed({3'b000, position_store}) + (POS_W+3)'(vel_drag);
  assign hit_top  = pos_sum < $signed({3'b000, top_limit});
  assign pos_top  = hit_top ? $signed({3'b000, top_limit}) : pos_sum;
  assign hit_ground = pos_top > $signed({3'b000, ground_limit});

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_num    = alt_num;
    div_den    = alt_den;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      ST_IDLE: begin
        if (in_xfer) state_next = ST_ALT;
      end
      ST_ALT: begin
        if (alt_trivial) begin
          state_next = ST_DENS;
        end else begin
          div_start  = 1'b1;
          state_next = ST_ALT_WAIT;
        end
      end
      ST_ALT_WAIT: begin
        if (div_done) state_next = ST_DENS;
      end
      ST_DENS: begin
        div_num = POS_W'(dens_off);
        div_den = POS_W'(SPAN);
        if (alt < START || dens_off >= SPAN) begin
          state_next = ST_HL;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DENS_WAIT;
        end
      end
      ST_DENS_WAIT: begin
        if (div_done) state_next = ST_MT;
      end
      ST_MT: begin
        mul_a      = MUL_A_W'(t_q);
        mul_b      = MUL_B_W'(onem_floor);
        state_next = ST_MT_RD;
      end
      ST_MT_RD: begin
        state_next = ST_HL;
      end
      ST_HL: begin
        mul_a      = MUL_A_W'(heat_store);
        mul_b      = MUL_B_W'(lift_gain);
        state_next = ST_LIFT;
      end
      ST_LIFT: begin
        mul_a      = MUL_A_W'(prod[32:16]);
        mul_b      = MUL_B_W'(dens);
        state_next = ST_VEL;
      end
      ST_VEL: begin
        state_next = ST_DRAG;
      end
      ST_DRAG: begin
        mul_a      = MUL_A_W'(vel_tmp);
        mul_b      = MUL_B_W'(drag_factor);
        state_next = ST_POS;
      end
      ST_POS: begin
        // keep the drag product in place while the output side stalls
        mul_a      = MUL_A_W'(vel_tmp);
        mul_b      = MUL_B_W'(drag_factor);
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_ALT: begin
        if (alt_trivial) alt <= alt_triv;
      end
      ST_ALT_WAIT: begin
        if (div_done) alt <= {1'b0, div_quo};
      end
      ST_DENS: begin
        if (alt < START) begin
          dens <= ONE_Q16;
        end else if (dens_off >= SPAN) begin
          dens <= dens_floor;
        end
      end
      ST_DENS_WAIT: begin
        if (div_done) t_q <= div_quo;
      end
      ST_MT_RD: begin
        dens <= dens_calc;
      end
      ST_VEL: begin
        vel_tmp <= sat_vel(vel_sum);
      end
      default: begin
      end
    endcase
  end

  // tick state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      heat_store     <= '0;
      velocity_store <= '0;
      position_store <= '0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      if (m_axis_tready) m_axis_tvalid <= 1'b0;
      if (in_xfer) heat_store <= heat_upd;
      if (state == ST_POS && out_free) begin
        position_store <= hit_ground ? ground_limit : pos_top[POS_W-1:0];
        velocity_store <= (hit_top || hit_ground) ? '0 : vel_drag;
        m_axis_tvalid  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_POS && out_free) begin
      out_position <= hit_ground ? ground_limit : pos_top[POS_W-1:0];
      out_velocity <= (hit_top || hit_ground) ? '0 : vel_drag;
      out_heat     <= heat_store;
      out_top      <= hit_top;
      out_ground   <= hit_ground;
    end
  end

  assign m_axis_tdata = {out_ground, out_top, out_heat, out_velocity, out_position};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_pull <= 17'd13107;
      lift_gain    <= 17'd27525;
      drag_factor  <= 17'd58982;
      heat_gain    <= 17'd721;
      heat_loss    <= 17'd557;
      min_density  <= 17'd31457;
      top_limit    <= 26'd1310720;
      ground_limit <= 26'd13107200;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRAVITY:  gravity_pull <= cfg_data[COEF_W-1:0];
        REG_LIFT:     lift_gain    <= cfg_data[COEF_W-1:0];
        REG_DRAG:     drag_factor  <= cfg_data[COEF_W-1:0];
        REG_HEAT_UP:  heat_gain    <= cfg_data[COEF_W-1:0];
        REG_HEAT_DN:  heat_loss    <= cfg_data[COEF_W-1:0];
        REG_MIN_DENS: min_density  <= cfg_data[COEF_W-1:0];
        REG_TOP:      top_limit    <= cfg_data[POS_W-1:0];
        REG_GROUND:   ground_limit <= cfg_data[POS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bvps_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .done  (div_done)
  );

  bvps_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

endmodule

// File: test/tb_buoyant_vertical_physics_step.sv
`timescale 1ns / 1ps

module tb_buoyant_vertical_physics_step;
  import bvps_pkg::*;

  localparam int DENS_PARAM = DENSITY_START_DEF;
  localparam longint Q_ONE = 65536;
  localparam longint V_TOP = 67108863;
  localparam longint V_BOTTOM = -67108864;

  // result word, first field in the highest bits
  typedef struct packed {
    logic                    at_ground;
    logic                    at_top;
    logic [COEF_W-1:0]       heat_level;
    logic signed [VEL_W-1:0] velocity;
    logic [POS_W-1:0]        position;
  } flight_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [71:0]           m_axis_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  buoyant_vertical_physics_step #(
    .DENSITY_START_Q16(DENS_PARAM)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // predictor copy of the registers
  longint gravity = 13107;
  longint lift_k = 27525;
  longint drag_k = 58982;
  longint heat_up = 721;
  longint heat_dn = 557;
  longint dens_floor_reg = 31457;
  longint top_lim = 1310720;
  longint ground_lim = 13107200;

  // predictor copy of the flight state
  longint heat_q = 0;
  longint vel_q = 0;
  longint pos_q = 0;

  logic    pending_ticks[$];
  flight_t expected_flight[$];
  int      ticks_queued = 0;
  int      ticks_accepted = 0;
  int      results_seen = 0;
  int      mismatches = 0;
  logic    tick_taken = 1'b0;

  int src_gap = 0;
  int src_calm = 0;
  int sink_gap = 0;
  int sink_calm = 0;
  int hold_left = 0;
  int next_hold_at = 300;

  function automatic longint clip_vel(input longint v);
    if (v > V_TOP) return V_TOP;
    if (v < V_BOTTOM) return V_BOTTOM;
    return v;
  endfunction

  function automatic flight_t advance_flight(input logic burner);
    longint alt, dens, floor_d, start, t, lift, v, p;
    flight_t r;
    r = '0;
    if (burner) begin
      heat_q = (heat_q + heat_up > Q_ONE) ? Q_ONE : heat_q + heat_up;
    end else begin
      heat_q = (heat_q > heat_dn) ? heat_q - heat_dn : 0;
    end

    // altitude as a fraction of the band, zero when the band is closed or the position is at or past the ground
    if (ground_lim <= top_lim || pos_q >= ground_lim) begin
      alt = 0;
    end else if (ground_lim - pos_q >= ground_lim - top_lim) begin
      alt = Q_ONE;
    end else begin
      alt = ((ground_lim - pos_q) << 16) / (ground_lim - top_lim);
    end

    floor_d = (dens_floor_reg > Q_ONE) ? Q_ONE : dens_floor_reg;
    start = longint'(DENS_PARAM) & 65535;
    if (alt < start) begin
      dens = Q_ONE;
    end else begin
      t = ((alt - start) << 16) / (Q_ONE - start);
      dens = Q_ONE - ((t * (Q_ONE - floor_d)) >> 16);
      if (dens < floor_d) dens = floor_d;
    end

    lift = (((heat_q * lift_k) >> 16) * dens) >> 16;
    v = clip_vel(vel_q + gravity - lift);
    v = clip_vel((v * drag_k) >>> 16);
    p = pos_q + v;
    if (p < top_lim) begin
      p = top_lim;
      v = 0;
      r.at_top = 1'b1;
    end
    if (p > ground_lim) begin
      p = ground_lim;
      v = 0;
      r.at_ground = 1'b1;
    end
    pos_q = p;
    vel_q = v;
    r.position = p[POS_W-1:0];
    r.velocity = v[VEL_W-1:0];
    r.heat_level = heat_q[COEF_W-1:0];
    return r;
  endfunction

  // mostly short gaps, now and then a long one, with calm stretches of none
  function automatic int pick_gap(inout int calm);
    int roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic check_field(input string what, input longint want, input longint got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // sender
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else if (!s_axis_tvalid || tick_taken) begin
      if (src_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        src_gap--;
      end else if (pending_ticks.size() != 0) begin
        s_axis_tdata <= {7'b0, pending_ticks.pop_front()};
        s_axis_tvalid <= 1'b1;
        src_gap = pick_gap(src_calm);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver, with a long hold-off now and then so the input side backs up
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (hold_left == 0 && results_seen >= next_hold_at) begin
        hold_left = 400;
        next_hold_at += 700;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        sink_gap = pick_gap(sink_calm);
      end
    end
  end

  // transfer monitor on both sides
  always @(posedge clk) begin : watch
    flight_t got, want;
    if (rst) begin
      tick_taken <= 1'b0;
    end else begin
      tick_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_flight.push_back(advance_flight(s_axis_tdata[0]));
        ticks_accepted++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        results_seen++;
        if (expected_flight.size() == 0) begin
          $display("%0t ns: result with none expected, actual %h", $time, m_axis_tdata);
          mismatches++;
        end else begin
          want = expected_flight.pop_front();
          check_field("position", longint'(want.position), longint'(got.position));
          check_field("velocity", longint'($signed(want.velocity)),
                      longint'($signed(got.velocity)));
          check_field("heat_level", longint'(want.heat_level), longint'(got.heat_level));
          check_field("at_top", longint'(want.at_top), longint'(got.at_top));
          check_field("at_ground", longint'(want.at_ground), longint'(got.at_ground));
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_GRAVITY:  gravity = longint'(val[COEF_W-1:0]);
      REG_LIFT:     lift_k = longint'(val[COEF_W-1:0]);
      REG_DRAG:     drag_k = longint'(val[COEF_W-1:0]);
      REG_HEAT_UP:  heat_up = longint'(val[COEF_W-1:0]);
      REG_HEAT_DN:  heat_dn = longint'(val[COEF_W-1:0]);
      REG_MIN_DENS: dens_floor_reg = longint'(val[COEF_W-1:0]);
      REG_TOP:      top_lim = longint'(val[POS_W-1:0]);
      REG_GROUND:   ground_lim = longint'(val[POS_W-1:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_tick(input logic burner);
    pending_ticks.push_back(burner);
    ticks_queued++;
  endtask

  task automatic settle();
    while (pending_ticks.size() != 0 || ticks_accepted != ticks_queued ||
           expected_flight.size() != 0) begin
      @(negedge clk);
    end
    repeat (50) @(negedge clk);
  endtask

  function automatic logic [COEF_W-1:0] pick_coef(input int lo, input int hi);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 12) return '0;
    if (roll < 22) return ONE_Q16;
    if (roll < 30) return 17'h1FFFF;
    if (roll < 42) return COEF_W'($urandom_range(0, 131071));
    return COEF_W'($urandom_range(lo, hi));
  endfunction

  // bits above the register width should be dropped by the block
  function automatic logic [CFG_DATA_W-1:0] pad_junk(input logic [COEF_W-1:0] c);
    return {(CFG_DATA_W-COEF_W)'($urandom()), c};
  endfunction

  task automatic random_setup();
    int roll;
    logic [POS_W-1:0] top_v, gnd_v;
    write_reg(REG_GRAVITY, pad_junk(pick_coef(4000, 30000)));
    write_reg(REG_LIFT, pad_junk(pick_coef(15000, 65536)));
    write_reg(REG_DRAG, pad_junk(pick_coef(45000, 65536)));
    write_reg(REG_HEAT_UP, pad_junk(pick_coef(300, 6000)));
    write_reg(REG_HEAT_DN, pad_junk(pick_coef(200, 5000)));
    write_reg(REG_MIN_DENS, pad_junk(pick_coef(0, 65536)));
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      top_v = POS_W'($urandom_range(0, 4000000));
      gnd_v = top_v + POS_W'($urandom_range(600000, 20000000));
    end else if (roll < 75) begin
      top_v = '0;
      gnd_v = '1;
    end else if (roll < 85) begin
      // closed band
      gnd_v = POS_W'($urandom_range(0, 30000000));
      top_v = gnd_v + POS_W'($urandom_range(0, 1000));
    end else begin
      top_v = POS_W'($urandom());
      gnd_v = POS_W'($urandom());
    end
    write_reg(REG_TOP, top_v);
    write_reg(REG_GROUND, gnd_v);
  endtask

  // burner runs of random length, long enough to climb and sink, plus some noise
  task automatic queue_flight(input int count);
    int left, run;
    logic burner;
    left = count;
    burner = 1'($urandom_range(0, 1));
    while (left > 0) begin
      if ($urandom_range(0, 99) < 15) begin
        queue_tick(1'($urandom_range(0, 1)));
        left--;
      end else begin
        run = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 40) : $urandom_range(40, 120);
        if (run > left) run = left;
        repeat (run) queue_tick(burner);
        left -= run;
        burner = ~burner;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // settings after reset: first tick pulls the position into the band
    repeat (6) queue_tick(1'b1);
    repeat (4) queue_tick(1'b0);
    settle();

    // top and ground on the same value, then swapped: both clamps fire
    write_reg(REG_TOP, 26'd6553600);
    write_reg(REG_GROUND, 26'd6553600);
    queue_tick(1'b1);
    queue_tick(1'b0);
    settle();
    write_reg(REG_TOP, 26'd13107200);
    write_reg(REG_GROUND, 26'd1310720);
    queue_tick(1'b0);
    queue_tick(1'b1);
    settle();

    // every coefficient at its full width, density floor above one
    write_reg(REG_GRAVITY, 26'h1FFFF);
    write_reg(REG_LIFT, 26'h1FFFF);
    write_reg(REG_DRAG, 26'h1FFFF);
    write_reg(REG_HEAT_UP, 26'h1FFFF);
    write_reg(REG_HEAT_DN, 26'h1FFFF);
    write_reg(REG_MIN_DENS, 26'h1FFFF);
    write_reg(REG_TOP, 26'd0);
    write_reg(REG_GROUND, 26'h3FFFFFF);
    queue_tick(1'b1);
    queue_tick(1'b1);
    queue_tick(1'b0);
    queue_tick(1'b1);
    settle();

    // everything at zero
    write_reg(REG_GRAVITY, 26'd0);
    write_reg(REG_LIFT, 26'd0);
    write_reg(REG_DRAG, 26'd0);
    write_reg(REG_HEAT_UP, 26'd0);
    write_reg(REG_HEAT_DN, 26'd0);
    write_reg(REG_MIN_DENS, 26'd0);
    write_reg(REG_GROUND, 26'd0);
    queue_tick(1'b1);
    queue_tick(1'b0);
    settle();

    // strong lift with drag above one; the climb is stopped at the top limit
    write_reg(REG_GROUND, 26'h3FFFFFF);
    write_reg(REG_LIFT, 26'h1FFFF);
    write_reg(REG_DRAG, 26'h1FFFF);
    write_reg(REG_HEAT_UP, CFG_DATA_W'(ONE_Q16));
    write_reg(REG_MIN_DENS, CFG_DATA_W'(ONE_Q16));
    repeat (3) queue_tick(1'b1);
    settle();

    repeat (13) begin
      random_setup();
      queue_flight($urandom_range(80, 120));
      settle();
    end

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
